// ===== rtl/core/hsvrgb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared widths and constants for the hsv to rgb converter and its
// channel arithmetic unit.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

    // field widths
    localparam int HUE_W    = 9;
    localparam int PCT_W    = 7;
    localparam int CH_W     = 8;
    localparam int K_W      = 6;
    localparam int REGION_W = 3;

    // datapath widths of the channel unit
    localparam int W_W      = 13;   // 6000 - s*k, up to 6000
    localparam int N_W      = 24;   // 17 * v * w, below 2^24
    localparam int MUL_A_W  = 24;
    localparam int MUL_B_W  = 17;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;

    // hue and percent limits
    localparam logic [HUE_W-1:0] HUE_WRAP       = HUE_W'(360);
    localparam logic [PCT_W-1:0] PCT_FULL       = PCT_W'(100);
    localparam logic [K_W-1:0]   HUE_REGION_DEG = K_W'(60);

    // channel = floor(255*v*w / 600000) = floor(17*v*w / 40000)
    localparam logic [W_W-1:0]     W_FULL    = W_W'(6000);
    localparam logic [MUL_B_W-1:0] DIV_CONST = MUL_B_W'(40000);
    // floor(2^32 / 40000), the quotient estimate is low by at most one
    localparam logic [MUL_B_W-1:0] RECIP_M   = MUL_B_W'(107374);
    localparam int                 RECIP_SH  = 32;

    // start of each 60 degree hue region
    function automatic logic [HUE_W-1:0] region_base(input logic [REGION_W-1:0] region);
        logic [HUE_W-1:0] base;
        case (region)
            3'd0:    base = HUE_W'(0);
            3'd1:    base = HUE_W'(60);
            3'd2:    base = HUE_W'(120);
            3'd3:    base = HUE_W'(180);
            3'd4:    base = HUE_W'(240);
            default: base = HUE_W'(300);
        endcase
        return base;
    endfunction

endpackage

// ===== rtl/core/hsv_to_rgb_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Converts hue, saturation and value to 8-bit red, green and blue.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries hue_deg, sat_pct, val_pct and
//   force_req. A request gives a result only when hue, saturation or value
//   differ from the last request that gave one, or force_req is set;
//   otherwise it is accepted and dropped.
//   Output channel out_valid/out_ready carries red, green and blue.
//   The four channel terms (v, p, q, t) are computed one after another on
//   a single shared multiplier, so a request with a result is finished
//   before the next one can be accepted.
//   in_ready is high only while the block is idle.
//   A finished result sits in the output register; when the receiver
//   stalls, the next request is accepted and computed, and it waits for
//   the output register to drain before it is posted.
//   Reset clears the last-seen hue, saturation and value to zero, so a
//   first request of all zeros without force gives no result.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter
    import hsvrgb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [HUE_W-1:0] hue_deg,
    input  logic [PCT_W-1:0] sat_pct,
    input  logic [PCT_W-1:0] val_pct,
    input  logic             force_req,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [CH_W-1:0]  red,
    output logic [CH_W-1:0]  green,
    output logic [CH_W-1:0]  blue
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [1:0] TERM_V = 2'd0;
    localparam logic [1:0] TERM_P = 2'd1;
    localparam logic [1:0] TERM_Q = 2'd2;
    localparam logic [1:0] TERM_T = 2'd3;

    logic [1:0]          state_reg;
    logic [1:0]          term_reg;
    logic                start_reg;
    logic                out_valid_reg;
    logic [HUE_W-1:0]    last_hue_reg;
    logic [PCT_W-1:0]    last_sat_reg;
    logic [PCT_W-1:0]    last_val_reg;
    logic [PCT_W-1:0]    s_reg;
    logic [PCT_W-1:0]    v_reg;
    logic [REGION_W-1:0] region_reg;
    logic [K_W-1:0]      rem_reg;
    logic [CH_W-1:0]     term_val_reg [0:3];
    logic [CH_W-1:0]     red_reg;
    logic [CH_W-1:0]     green_reg;
    logic [CH_W-1:0]     blue_reg;

    logic                accept;
    logic                changed;
    logic [HUE_W-1:0]    h;
    logic [REGION_W-1:0] region;
    logic [HUE_W-1:0]    base;
    logic [K_W-1:0]      k;
    logic                unit_done;
    logic [CH_W-1:0]     unit_chan;
    logic                out_free;
    logic [CH_W-1:0]     cv;
    logic [CH_W-1:0]     cp;
    logic [CH_W-1:0]     cq;
    logic [CH_W-1:0]     ct;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign changed  = force_req || (hue_deg != last_hue_reg) ||
                      (sat_pct != last_sat_reg) || (val_pct != last_val_reg);
    assign out_free = !out_valid_reg || out_ready;

    // hue limit (360 and above read as 0) and region split
    assign h = (hue_deg >= HUE_WRAP) ? '0 : hue_deg;

    always_comb
    begin
        if (h >= HUE_W'(300))
            region = 3'd5;
        else if (h >= HUE_W'(240))
            region = 3'd4;
        else if (h >= HUE_W'(180))
            region = 3'd3;
        else if (h >= HUE_W'(120))
            region = 3'd2;
        else if (h >= HUE_W'(60))
            region = 3'd1;
        else
            region = 3'd0;
    end

    assign base = region_base(region);

    // hue weight for the term in progress
    always_comb
    begin
        case (term_reg)
            TERM_V:  k = '0;
            TERM_P:  k = HUE_REGION_DEG;
            TERM_Q:  k = rem_reg;
            default: k = HUE_REGION_DEG - rem_reg;
        endcase
    end

    hsvrgb_chan_unit u_chan
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .v     (v_reg),
        .s     (s_reg),
        .k     (k),
        .done  (unit_done),
        .chan  (unit_chan)
    );

    // request capture with clamping
    always_ff @(posedge clk)
    begin
        if (accept && changed)
        begin
            s_reg      <= (sat_pct > PCT_FULL) ? PCT_FULL : sat_pct;
            v_reg      <= (val_pct > PCT_FULL) ? PCT_FULL : val_pct;
            region_reg <= region;
            rem_reg    <= K_W'(h - base);
        end
        if (unit_done)
        begin
            term_val_reg[term_reg] <= unit_chan;
        end
    end

    // last emitted inputs for change detection
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_hue_reg <= '0;
            last_sat_reg <= '0;
            last_val_reg <= '0;
        end
        else if (accept && changed)
        begin
            last_hue_reg <= hue_deg;
            last_sat_reg <= sat_pct;
            last_val_reg <= val_pct;
        end
    end

    // term sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            term_reg  <= TERM_V;
            start_reg <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && changed)
                    begin
                        state_reg <= ST_RUN;
                        term_reg  <= TERM_V;
                        start_reg <= 1'b1;
                    end
                end
                ST_RUN:
                begin
                    if (unit_done)
                    begin
                        if (term_reg == TERM_T)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            term_reg  <= term_reg + 2'd1;
                            start_reg <= 1'b1;
                        end
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // map terms to channels by hue region
    assign cv = term_val_reg[TERM_V];
    assign cp = term_val_reg[TERM_P];
    assign cq = term_val_reg[TERM_Q];
    assign ct = term_val_reg[TERM_T];

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            case (region_reg)
                3'd0:    begin red_reg <= cv; green_reg <= ct; blue_reg <= cp; end
                3'd1:    begin red_reg <= cq; green_reg <= cv; blue_reg <= cp; end
                3'd2:    begin red_reg <= cp; green_reg <= cv; blue_reg <= ct; end
                3'd3:    begin red_reg <= cp; green_reg <= cq; blue_reg <= cv; end
                3'd4:    begin red_reg <= ct; green_reg <= cp; blue_reg <= cv; end
                default: begin red_reg <= cv; green_reg <= cp; blue_reg <= cq; end
            endcase
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

// ===== rtl/core/hsvrgb_chan_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_chan_unit
// Computes one 8-bit channel floor(255*v*(6000 - s*k)/600000) with a single
// shared multiplier stepped by a small sequencer: s*k, v*w, reciprocal
// estimate of the quotient, back-multiply and one correction step.
// ----------------------------------------------------------------------------
module hsvrgb_chan_unit
    import hsvrgb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [PCT_W-1:0] v,
    input  logic [PCT_W-1:0] s,
    input  logic [K_W-1:0]   k,
    output logic             done,
    output logic [CH_W-1:0]  chan
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SK   = 3'd1;
    localparam logic [2:0] ST_VW   = 3'd2;
    localparam logic [2:0] ST_RC   = 3'd3;
    localparam logic [2:0] ST_FX   = 3'd4;
    localparam logic [2:0] ST_CR   = 3'd5;

    logic [2:0]         step_reg;
    logic [PCT_W-1:0]   v_reg;
    logic [PCT_W-1:0]   s_reg;
    logic [K_W-1:0]     k_reg;
    logic [N_W-1:0]     n_reg;
    logic [CH_W-1:0]    q0_reg;
    logic [PROD_W-1:0]  prod_reg;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [W_W-1:0]     w;
    logic [N_W-1:0]     n;
    logic [N_W-1:0]     rem;

    // intermediate terms from the last product
    assign w   = W_FULL - prod_reg[W_W-1:0];
    assign n   = {prod_reg[N_W-5:0], 4'b0000} + N_W'(prod_reg[N_W-5:0]);
    assign rem = n_reg - prod_reg[N_W-1:0];

    // operand select for the shared multiplier
    always_comb
    begin
        case (step_reg)
            ST_SK:
            begin
                mul_a = MUL_A_W'(s_reg);
                mul_b = MUL_B_W'(k_reg);
            end
            ST_VW:
            begin
                mul_a = MUL_A_W'(v_reg);
                mul_b = MUL_B_W'(w);
            end
            ST_RC:
            begin
                mul_a = MUL_A_W'(n);
                mul_b = RECIP_M;
            end
            ST_FX:
            begin
                // quotient estimate straight from the reciprocal product
                mul_a = MUL_A_W'(prod_reg[RECIP_SH+CH_W-1:RECIP_SH]);
                mul_b = DIV_CONST;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // shared multiplier with registered product
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // operand and intermediate registers
    always_ff @(posedge clk)
    begin
        if (step_reg == ST_IDLE && start)
        begin
            v_reg <= v;
            s_reg <= s;
            k_reg <= k;
        end
        if (step_reg == ST_RC)
        begin
            n_reg <= n;
        end
        if (step_reg == ST_FX)
        begin
            q0_reg <= prod_reg[RECIP_SH+CH_W-1:RECIP_SH];
        end
    end

    // step sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
        end
        else
        begin
            case (step_reg)
                ST_IDLE: if (start) step_reg <= ST_SK;
                ST_SK:   step_reg <= ST_VW;
                ST_VW:   step_reg <= ST_RC;
                ST_RC:   step_reg <= ST_FX;
                ST_FX:   step_reg <= ST_CR;
                default: step_reg <= ST_IDLE;
            endcase
        end
    end

    // correct the low estimate by one where the remainder is still too large
    assign done = (step_reg == ST_CR);
    assign chan = q0_reg + CH_W'(rem >= N_W'(DIV_CONST));

endmodule
